// ===== design/wlh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wlh_pkg;

  // table sizes
  localparam int TASK_SLOTS   = 1024;
  localparam int GROUP_SLOTS  = 16;
  localparam int BUCKET_COUNT = 32;

  // fixed field widths
  localparam int SLOT_IN_W  = 10;
  localparam int TIME_W     = 64;
  localparam int COUNT_W    = 64;
  localparam int BUCKET_W   = 5;
  localparam int GROUP_W    = 4;

  localparam int NS_PER_US  = 1000;

  // derived widths
  localparam int TASK_AW     = $clog2(TASK_SLOTS);
  localparam int GROUP_AW    = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int BUCKET_AW   = $clog2(BUCKET_COUNT);
  localparam int EVENT_DEPTH = GROUP_SLOTS * BUCKET_COUNT;
  localparam int EVENT_AW    = $clog2(EVENT_DEPTH);
  localparam int CLEAR_LEN   = (TASK_SLOTS > EVENT_DEPTH) ? TASK_SLOTS : EVENT_DEPTH;
  localparam int CLEAR_W     = $clog2(CLEAR_LEN);
  localparam int THERM_W     = BUCKET_COUNT - 1;
  localparam int CMP_W       = TIME_W + 11;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_RECORDED = 2'd0;
  localparam status_t ST_NO_START = 2'd1;
  localparam status_t ST_COUNTED  = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // one task table entry
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] stamp;
  } task_entry_t;

  // reduce the raw slot field into the task table, one compare-subtract per bit
  function automatic logic [TASK_AW-1:0] task_index(input logic [SLOT_IN_W-1:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    for (int k = SLOT_IN_W - 1; k >= 0; k--) begin
      if (v >= (32'(TASK_SLOTS) << k)) begin
        v = v - (32'(TASK_SLOTS) << k);
      end
    end
    return TASK_AW'(v);
  endfunction

endpackage

`default_nettype wire

// ===== design/wakeup_latency_log2_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-control-group log2 histogram of wakeup-to-run latency. A wakeup beat
// (req_type 0) stores now_ns for its task slot; a switch beat (req_type 1)
// consumes that stamp, takes (now_ns - stamp) in microseconds, picks bucket
// floor(log2) clamped to the top bucket, finds or claims the cgroup slot and
// bumps the 64-bit counter, returning the new count. Every input beat gives
// exactly one result beat. Items are handled one at a time: a wakeup goes
// from accept straight to the result state, a switch through at most the
// task, bucket, read and increment states, set by the read-modify-write of
// the task table and then the counter memory, each with a registered read. A
// result held by out_stall holds the last step, blocking the next accept.
// After reset a clearing pass zeros both memories, one entry a cycle, with in_stall held high.
module wakeup_latency_log2_histogram (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           req_type,
  input  wire  [wlh_pkg::SLOT_IN_W-1:0] task_slot,
  input  wire  [wlh_pkg::TIME_W-1:0]    now_ns,
  input  wire  [wlh_pkg::TIME_W-1:0]    cg_id,
  output logic                          out_valid,
  input  wire                           out_stall,
  output wlh_pkg::status_t              status,
  output logic [wlh_pkg::BUCKET_W-1:0]  bucket,
  output logic [wlh_pkg::GROUP_W-1:0]   group_slot,
  output logic [wlh_pkg::COUNT_W-1:0]   new_count
);
  import wlh_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TASK  = 3'd2;
  localparam logic [2:0] S_BUCK  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_INC   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CLEAR_W-1:0] clr;

  // memories
  task_entry_t        task_mem [TASK_SLOTS];
  logic [COUNT_W-1:0] count_mem [EVENT_DEPTH];
  task_entry_t        task_rdata;
  logic [COUNT_W-1:0] count_rdata;

  // group table in flops
  logic [TIME_W-1:0]      group_key [GROUP_SLOTS];
  logic [GROUP_SLOTS-1:0] group_used;

  // current item
  logic [TASK_AW-1:0]  it_slot;
  logic [TIME_W-1:0]   it_now;
  logic [TIME_W-1:0]   it_cg;
  logic [TIME_W-1:0]   diff;
  logic [THERM_W-1:0]  therm;
  logic                hit;
  logic [GROUP_AW-1:0] hit_idx;
  logic                free_any;
  logic [GROUP_AW-1:0] free_idx;
  logic [GROUP_AW-1:0] grp;
  logic [BUCKET_AW-1:0] bkt;

  // staged result
  status_t             res_status;
  logic [BUCKET_AW-1:0] res_bucket;
  logic [GROUP_AW-1:0] res_group;
  logic [COUNT_W-1:0]  res_count;

  logic                accept;
  logic                out_free;
  logic [TASK_AW-1:0]  in_slot;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_slot  = task_index(task_slot);

  // group lookup against every claimed slot
  logic                m_hit;
  logic [GROUP_AW-1:0] m_hit_idx;
  logic                m_free;
  logic [GROUP_AW-1:0] m_free_idx;
  always_comb begin
    m_hit      = 1'b0;
    m_hit_idx  = '0;
    m_free     = 1'b0;
    m_free_idx = '0;
    for (int g = GROUP_SLOTS - 1; g >= 0; g--) begin
      if (group_used[g] && group_key[g] == it_cg) begin
        m_hit     = 1'b1;
        m_hit_idx = GROUP_AW'(g);
      end
      if (!group_used[g]) begin
        m_free     = 1'b1;
        m_free_idx = GROUP_AW'(g);
      end
    end
  end

  // thermometer of diff >= 1000 * 2^b against constant thresholds
  logic [THERM_W-1:0] therm_next;
  always_comb begin
    for (int b = 1; b < BUCKET_COUNT; b++) begin
      therm_next[b-1] = ({11'd0, diff} >= (CMP_W'(NS_PER_US) << b));
    end
  end

  // bucket is the height of the thermometer
  logic [BUCKET_AW-1:0] bkt_next;
  always_comb begin
    bkt_next = '0;
    for (int i = 0; i < THERM_W; i++) begin
      if (therm[i]) begin
        bkt_next = BUCKET_AW'(i + 1);
      end
    end
  end

  logic [EVENT_AW-1:0] count_raddr;
  assign count_raddr = EVENT_AW'(EVENT_AW'(grp) * EVENT_AW'(BUCKET_COUNT)
                       + EVENT_AW'(bkt_next));
  logic [EVENT_AW-1:0] count_addr;

  // task table write port
  logic               task_we;
  logic [TASK_AW-1:0] task_waddr;
  task_entry_t        task_wdata;
  always_comb begin
    task_we    = 1'b0;
    task_waddr = in_slot;
    task_wdata = '{valid: 1'b1, stamp: now_ns};
    if (state == S_CLEAR) begin
      task_we    = ({1'b0, clr} < (CLEAR_W + 1)'(TASK_SLOTS));
      task_waddr = clr[TASK_AW-1:0];
      task_wdata = '0;
    end else if (accept && !req_type) begin
      task_we = 1'b1;
    end else if (state == S_TASK && task_rdata.valid) begin
      task_we    = 1'b1;
      task_waddr = it_slot;
      task_wdata = '{valid: 1'b0, stamp: task_rdata.stamp};
    end
  end

  // counter memory write port
  logic                count_we;
  logic [EVENT_AW-1:0] count_waddr;
  logic [COUNT_W-1:0]  count_wdata;
  logic [COUNT_W-1:0]  count_inc;
  assign count_inc = count_rdata + COUNT_W'(1);
  always_comb begin
    count_we    = 1'b0;
    count_waddr = count_addr;
    count_wdata = count_inc;
    if (state == S_CLEAR) begin
      count_we    = ({1'b0, clr} < (CLEAR_W + 1)'(EVENT_DEPTH));
      count_waddr = clr[EVENT_AW-1:0];
      count_wdata = '0;
    end else if (state == S_INC) begin
      count_we = 1'b1;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (task_we) begin
      task_mem[task_waddr] <= task_wdata;
    end
    if (accept) begin
      task_rdata <= task_mem[in_slot];
    end
    if (count_we) begin
      count_mem[count_waddr] <= count_wdata;
    end
    if (state == S_READ) begin
      count_rdata <= count_mem[count_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == CLEAR_W'(CLEAR_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = req_type ? S_TASK : S_DONE;
        end
      end
      S_TASK:  state_next = task_rdata.valid ? S_BUCK : S_DONE;
      S_BUCK:  state_next = (hit || free_any) ? S_READ : S_DONE;
      S_READ:  state_next = S_INC;
      S_INC:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      out_valid  <= 1'b0;
      group_used <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + CLEAR_W'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_BUCK && !hit && free_any) begin
        group_used[free_idx] <= 1'b1;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      it_slot    <= in_slot;
      it_now     <= now_ns;
      it_cg      <= cg_id;
      res_status <= ST_RECORDED;
      res_bucket <= '0;
      res_group  <= '0;
      res_count  <= '0;
    end
    if (state == S_TASK) begin
      diff     <= it_now - task_rdata.stamp;
      hit      <= m_hit;
      hit_idx  <= m_hit_idx;
      free_any <= m_free;
      free_idx <= m_free_idx;
      if (!task_rdata.valid) begin
        res_status <= ST_NO_START;
      end
    end
    if (state == S_BUCK) begin
      therm <= therm_next;
      if (hit) begin
        grp <= hit_idx;
      end else if (free_any) begin
        grp                 <= free_idx;
        group_key[free_idx] <= it_cg;
      end else begin
        res_status <= ST_FULL;
      end
    end
    if (state == S_READ) begin
      bkt        <= bkt_next;
      count_addr <= count_raddr;
    end
    if (state == S_INC) begin
      res_status <= ST_COUNTED;
      res_bucket <= bkt;
      res_group  <= grp;
      res_count  <= count_inc;
    end
    if (state == S_DONE && out_free) begin
      status     <= res_status;
      bucket     <= BUCKET_W'(res_bucket);
      group_slot <= GROUP_W'(res_group);
      new_count  <= res_count;
    end
  end

`ifndef SYNTHESIS
  // only a counted beat carries bucket, slot and count
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_COUNTED) |->
      (bucket == '0 && group_slot == '0 && new_count == '0))
    else $error("non-counted result carries payload");

  // no result during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during clearing pass");

  // claimed group slots are never released
  a_used_sticky: assert property (@(posedge clk) disable iff (rst)
    ((group_used & $past(group_used)) == $past(group_used)))
    else $error("group slot released");

  // a wakeup goes straight to its result
  a_wakeup_short: assert property (@(posedge clk) disable iff (rst)
    (accept && !req_type) |=> (state == S_DONE && res_status == ST_RECORDED))
    else $error("wakeup took the switch path");
`endif

endmodule

`default_nettype wire
